// ----- hdl/spdt_pkg.sv -----
// Shared types, constants and helper functions of the SPD timing converter.
package spdt_pkg;

   // Field and datapath widths
   localparam int BYTE_W  = 8;
   localparam int TRFC_W  = 16;
   localparam int CYC_W   = 10;
   localparam int CL_W    = 6;
   localparam int DIV_W   = 16;
   localparam int DEN_W   = CYC_W + 2;
   localparam int CNT_W   = $clog2(DIV_W);
   localparam int CSR_W   = CYC_W;

   // Configuration reset values
   localparam logic [CYC_W-1:0] DRAM_CYCLE_RST  = 10'd500;
   localparam logic [CL_W-1:0]  CAS_LATENCY_RST = 6'd30;

   // Configuration register indexes
   localparam logic CSR_DRAM_CYCLE  = 1'b0;
   localparam logic CSR_CAS_LATENCY = 1'b1;

   // Clamp limits of the controller fields
   localparam logic [4:0] QTR_LO    = 5'd2;
   localparam logic [4:0] QTR_HI6   = 5'd6;
   localparam logic [4:0] QTR_HI5   = 5'd5;
   localparam logic [4:0] TRAS_LO   = 5'd5;
   localparam logic [4:0] TRAS_HI   = 5'd20;
   localparam logic [6:0] TRFC_MIN  = 7'd8;
   localparam logic [6:0] TRFC_MAX  = 7'd71;
   localparam logic [5:0] TRFC_LOW_CODE = 6'd56;
   localparam logic [1:0] TRTP_2T_MAX   = 2'd2;
   localparam logic [TRFC_W-1:0] TRFC_EXT_256NS = 16'd25600;

   // CAS latency limits and encode thresholds, tenths of a cycle
   localparam logic [CL_W-1:0] CL_MIN  = 6'd20;
   localparam logic [CL_W-1:0] CL_30   = 6'd30;
   localparam logic [CL_W-1:0] CL_40   = 6'd40;
   localparam logic [CL_W-1:0] CL_MAX  = 6'd50;

   // Running maxima of one set of sockets
   typedef struct packed {
      logic [BYTE_W-1:0] trp;
      logic [BYTE_W-1:0] trcd;
      logic [BYTE_W-1:0] tras;
      logic [TRFC_W-1:0] trfc;
      logic [BYTE_W-1:0] trrd;
      logic [BYTE_W-1:0] twr;
      logic [BYTE_W-1:0] twtr;
      logic [BYTE_W-1:0] trtp;
   } max_set_type;

   typedef struct packed {
      logic [CYC_W-1:0] dram_cycle;
      logic [CL_W-1:0]  cas_latency;
   } cfg_type;

   typedef struct packed {
      logic [1:0] cl_code;
      logic [2:0] trp_code;
      logic [2:0] trcd_code;
      logic [3:0] tras_code;
      logic [5:0] trfc_code;
      logic [1:0] trrd_code;
      logic [2:0] twr_code;
      logic [1:0] twtr_code;
      logic       trtp_long;
   } result_type;

   // Status of the queue, read by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      OP_TRP, OP_TRCD, OP_TRAS, OP_TRFC, OP_TRRD, OP_TWR, OP_TWTR, OP_TRTP
   } op_type;

   typedef enum logic [2:0] {
      B_IDLE, B_LOAD, B_DIV, B_STORE, B_DONE
   } back_state_type;

   // Fractional part of the refresh extension, hundredths of a ns
   function automatic logic [6:0] trfc_frac(input logic [2:0] code);
      logic [6:0] f;
      case (code)
         3'd1:    f = 7'd25;
         3'd2:    f = 7'd33;
         3'd3:    f = 7'd50;
         3'd4:    f = 7'd66;
         3'd5:    f = 7'd75;
         default: f = 7'd0;
      endcase
      return f;
   endfunction

   // Multiply a byte by 100 with shifts and adds
   function automatic logic [14:0] times_100(input logic [BYTE_W-1:0] b);
      logic [14:0] w;
      w = {7'd0, b};
      return (w << 6) + (w << 5) + (w << 2);
   endfunction

   // Refresh time in hundredths of a ns, extension included
   function automatic logic [TRFC_W-1:0] trfc_time(input logic [BYTE_W-1:0] b,
                                                   input logic [BYTE_W-1:0] ext);
      logic [TRFC_W-1:0] t;
      t = {1'b0, times_100(b)} + {9'd0, trfc_frac(ext[3:1])};
      if (ext[0]) begin
         t = t + TRFC_EXT_256NS;
      end
      return t;
   endfunction

   // Clamp a cycle count to lo..hi and subtract lo
   function automatic logic [4:0] clamp_code(input logic [DIV_W-1:0] q,
                                             input logic [4:0] lo,
                                             input logic [4:0] hi);
      logic [4:0] v;
      if (q > {11'd0, hi}) begin
         v = hi;
      end else if (q < {11'd0, lo}) begin
         v = lo;
      end else begin
         v = q[4:0];
      end
      return v - lo;
   endfunction

   // Refresh field: capped at the maximum, special code below the minimum
   function automatic logic [5:0] trfc_encode(input logic [DIV_W-1:0] q);
      logic [6:0] v;
      if (q > {9'd0, TRFC_MAX}) begin
         v = TRFC_MAX - TRFC_MIN;
      end else if (q < {9'd0, TRFC_MIN}) begin
         v = {1'b0, TRFC_LOW_CODE};
      end else begin
         v = q[6:0] - TRFC_MIN;
      end
      return v[5:0];
   endfunction

   // CAS latency field, from a latency already saturated to its legal range
   function automatic logic [1:0] cl_encode(input logic [CL_W-1:0] cl);
      logic [1:0] c;
      if (cl >= CL_MAX) begin
         c = 2'd3;
      end else if (cl >= CL_40) begin
         c = 2'd2;
      end else if (cl >= CL_30) begin
         c = 2'd1;
      end else begin
         c = 2'd0;
      end
      return c;
   endfunction

endpackage

// ----- hdl/spdt_channels.sv -----
// Request and response channel interfaces of the SPD timing converter.
interface spdt_req_if;
   import spdt_pkg::*;
   logic              valid;
   logic              ready;
   logic              present;
   logic [BYTE_W-1:0] trp_byte;
   logic [BYTE_W-1:0] trcd_byte;
   logic [BYTE_W-1:0] tras_byte;
   logic [BYTE_W-1:0] trfc_byte;
   logic [BYTE_W-1:0] trfc_ext_byte;
   logic [BYTE_W-1:0] trrd_byte;
   logic [BYTE_W-1:0] twr_byte;
   logic [BYTE_W-1:0] twtr_byte;
   logic [BYTE_W-1:0] trtp_byte;
   logic              last;

   modport source (output valid, present, trp_byte, trcd_byte, tras_byte, trfc_byte,
                   trfc_ext_byte, trrd_byte, twr_byte, twtr_byte, trtp_byte, last,
                   input ready);
   modport sink (input valid, present, trp_byte, trcd_byte, tras_byte, trfc_byte,
                 trfc_ext_byte, trrd_byte, twr_byte, twtr_byte, trtp_byte, last,
                 output ready);
endinterface

interface spdt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] cl_code;
   logic [2:0] trp_code;
   logic [2:0] trcd_code;
   logic [3:0] tras_code;
   logic [5:0] trfc_code;
   logic [1:0] trrd_code;
   logic [2:0] twr_code;
   logic [1:0] twtr_code;
   logic       trtp_long;

   modport source (output valid, cl_code, trp_code, trcd_code, tras_code, trfc_code,
                   trrd_code, twr_code, twtr_code, trtp_long, input ready);
   modport sink (input valid, cl_code, trp_code, trcd_code, tras_code, trfc_code,
                 trrd_code, twr_code, twtr_code, trtp_long, output ready);
endinterface

// ----- hdl/dram_timing_from_spd.sv -----
// Top level of the SPD to DRAM timing converter.
//
//   channel  direction  handshake      carries
//   req_bus  in         valid/ready    one socket: presence, SPD timing bytes, last
//   rsp_bus  out        valid/ready    one set of encoded controller timing fields
//   csr_*    in         write enable   dram_cycle (index 0), cas_latency (index 1)
//
// A present request without last is folded into the registered maxima.
// In the back end a set is popped, each of its eight timings then takes a load, 16 steps
// of the shared radix-2 divider and an encode step, and the output is loaded last.
// Up to two finished sets wait in the queue; req_bus stalls only when it is full.
// The output register holds a response while rsp_bus stalls. Reset is synchronous
// and clears maxima, queue and control; no clearing pass is needed.
module dram_timing_from_spd (
   input  logic                         clock,
   input  logic                         reset,
   spdt_req_if.sink                     req_bus,
   spdt_rsp_if.source                   rsp_bus,
   input  logic                         csr_wr_en,
   input  logic                         csr_index,
   input  logic [spdt_pkg::CSR_W-1:0]   csr_wr_data
);
   import spdt_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             push;
   logic             pop;
   max_set_type      push_data;
   max_set_type      head;
   queue_status_type q_status;

   // Write configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DRAM_CYCLE:  cfg_in.dram_cycle  = csr_wr_data;
            CSR_CAS_LATENCY: cfg_in.cas_latency = csr_wr_data[CL_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dram_cycle  <= DRAM_CYCLE_RST;
         cfg_ff.cas_latency <= CAS_LATENCY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   spdt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   spdt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   spdt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );
endmodule

// ----- hdl/spdt_queue.sv -----
// Two-entry queue of finished maxima sets between front and back.
module spdt_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  spdt_pkg::max_set_type    push_data,
   input  logic                     pop,
   output spdt_pkg::max_set_type    head,
   output spdt_pkg::queue_status_type status
);
   import spdt_pkg::*;

   max_set_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed sets
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = count_ff[1];
   assign status.empty = (count_ff == 2'd0);
endmodule

// ----- hdl/spdt_front.sv -----
// Front end: takes socket requests, keeps running maxima, hands off each set.
module spdt_front (
   input  logic                      clock,
   input  logic                      reset,
   spdt_req_if.sink                  req_bus,
   input  spdt_pkg::queue_status_type q_status,
   output logic                      push,
   output spdt_pkg::max_set_type     push_data
);
   import spdt_pkg::*;

   max_set_type max_ff, max_in;
   max_set_type upd;
   logic        accept;
   logic [TRFC_W-1:0] rfc;

   assign req_bus.ready = ~q_status.full;
   assign accept        = req_bus.valid & req_bus.ready;
   assign rfc           = trfc_time(req_bus.trfc_byte, req_bus.trfc_ext_byte);

   // Fold a present socket into the maxima
   always_comb begin
      upd = max_ff;
      if (accept && req_bus.present) begin
         if (req_bus.trp_byte > max_ff.trp)   upd.trp  = req_bus.trp_byte;
         if (req_bus.trcd_byte > max_ff.trcd) upd.trcd = req_bus.trcd_byte;
         if (req_bus.tras_byte > max_ff.tras) upd.tras = req_bus.tras_byte;
         if (rfc > max_ff.trfc)               upd.trfc = rfc;
         if (req_bus.trrd_byte > max_ff.trrd) upd.trrd = req_bus.trrd_byte;
         if (req_bus.twr_byte > max_ff.twr)   upd.twr  = req_bus.twr_byte;
         if (req_bus.twtr_byte > max_ff.twtr) upd.twtr = req_bus.twtr_byte;
         if (req_bus.trtp_byte > max_ff.trtp) upd.trtp = req_bus.trtp_byte;
      end
   end

   // Hand off the set on the last socket and clear the maxima
   always_comb begin
      push      = accept & req_bus.last;
      push_data = upd;
      max_in    = push ? '0 : upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= '0;
      end else begin
         max_ff <= max_in;
      end
   end
endmodule

// ----- hdl/spdt_back.sv -----
// Back end: converts a maxima set to cycle counts with a shared serial divider.
module spdt_back (
   input  logic                       clock,
   input  logic                       reset,
   input  spdt_pkg::cfg_type          cfg,
   input  spdt_pkg::max_set_type      head,
   input  spdt_pkg::queue_status_type q_status,
   output logic                       pop,
   spdt_rsp_if.source                 rsp_bus
);
   import spdt_pkg::*;

   back_state_type    state_ff, state_in;
   op_type            op_ff, op_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   max_set_type       set_ff, set_in;
   result_type        res_ff, res_in;
   result_type        out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   logic              out_free;
   logic              out_load;
   logic [CYC_W-1:0]  cyc;
   logic              quarter;
   logic [DIV_W-1:0]  dividend;
   logic [DEN_W-1:0]  den_sel;
   logic [DIV_W:0]    biased;
   logic [DEN_W:0]    trial;
   logic              ge;
   logic [CL_W-1:0]   cl;

   assign out_free = ~out_valid_ff | rsp_bus.ready;
   assign cyc      = (cfg.dram_cycle == '0) ? {{(CYC_W-1){1'b0}}, 1'b1} : cfg.dram_cycle;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:  if (!q_status.empty) state_in = B_LOAD;
         B_LOAD:  state_in = B_DIV;
         B_DIV:   if (cnt_ff == CNT_W'(DIV_W - 1)) state_in = B_STORE;
         B_STORE: state_in = (op_ff == OP_TRTP) ? B_DONE : B_LOAD;
         B_DONE:  if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      pop      = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         B_IDLE:  pop = ~q_status.empty;
         B_DONE:  out_load = out_free;
         default: begin
            pop      = 1'b0;
            out_load = 1'b0;
         end
      endcase
   end

   // Select the dividend and divisor of the current timing
   always_comb begin
      quarter  = 1'b1;
      dividend = '0;
      case (op_ff)
         OP_TRP:  dividend = {1'b0, times_100(set_ff.trp)};
         OP_TRCD: dividend = {1'b0, times_100(set_ff.trcd)};
         OP_TRAS: begin
            dividend = {1'b0, times_100(set_ff.tras)};
            quarter  = 1'b0;
         end
         OP_TRFC: begin
            dividend = set_ff.trfc;
            quarter  = 1'b0;
         end
         OP_TRRD: dividend = {1'b0, times_100(set_ff.trrd)};
         OP_TWR:  dividend = {1'b0, times_100(set_ff.twr)};
         OP_TWTR: dividend = {1'b0, times_100(set_ff.twtr)};
         OP_TRTP: dividend = {1'b0, times_100(set_ff.trtp)};
         default: dividend = '0;
      endcase
      den_sel = quarter ? {cyc, 2'b00} : {2'b00, cyc};
      // Ceiling division: bias the dividend by divisor minus one
      biased  = {1'b0, dividend} + {5'd0, den_sel} - {{DIV_W{1'b0}}, 1'b1};
   end

   // One restoring division step
   assign trial = {rem_ff, num_ff[DIV_W-1]};
   assign ge    = (trial >= {1'b0, den_ff});

   // CAS latency saturated to its legal range
   always_comb begin
      cl = cfg.cas_latency;
      if (cl < CL_MIN) cl = CL_MIN;
      if (cl > CL_MAX) cl = CL_MAX;
   end

   // Datapath next values
   always_comb begin
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      set_in       = set_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff & ~rsp_bus.ready;
      if (pop) begin
         set_in = head;
         op_in  = OP_TRP;
      end
      case (state_ff)
         B_LOAD: begin
            num_in = biased[DIV_W-1:0];
            rem_in = '0;
            den_in = den_sel;
            cnt_in = '0;
         end
         B_DIV: begin
            rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            num_in = {num_ff[DIV_W-2:0], ge};
            cnt_in = cnt_ff + CNT_W'(1);
         end
         B_STORE: begin
            case (op_ff)
               OP_TRP:  res_in.trp_code  = 3'(clamp_code(num_ff, QTR_LO, QTR_HI6));
               OP_TRCD: res_in.trcd_code = 3'(clamp_code(num_ff, QTR_LO, QTR_HI6));
               OP_TRAS: res_in.tras_code = 4'(clamp_code(num_ff, TRAS_LO, TRAS_HI));
               OP_TRFC: res_in.trfc_code = trfc_encode(num_ff);
               OP_TRRD: res_in.trrd_code = 2'(clamp_code(num_ff, QTR_LO, QTR_HI5));
               OP_TWR:  res_in.twr_code  = 3'(clamp_code(num_ff, QTR_LO, QTR_HI6));
               OP_TWTR: res_in.twtr_code = 2'(clamp_code(num_ff, QTR_LO, QTR_HI5));
               OP_TRTP: res_in.trtp_long = (num_ff > {14'd0, TRTP_2T_MAX});
               default: res_in = res_ff;
            endcase
            op_in = op_type'(op_ff + 3'd1);
         end
         default: begin
            num_in = num_ff;
         end
      endcase
      // Load the output register; it holds while the sink stalls
      if (out_load) begin
         out_in         = res_ff;
         out_in.cl_code = cl_encode(cl);
         out_valid_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      set_ff <= set_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.cl_code   = out_ff.cl_code;
   assign rsp_bus.trp_code  = out_ff.trp_code;
   assign rsp_bus.trcd_code = out_ff.trcd_code;
   assign rsp_bus.tras_code = out_ff.tras_code;
   assign rsp_bus.trfc_code = out_ff.trfc_code;
   assign rsp_bus.trrd_code = out_ff.trrd_code;
   assign rsp_bus.twr_code  = out_ff.twr_code;
   assign rsp_bus.twtr_code = out_ff.twtr_code;
   assign rsp_bus.trtp_long = out_ff.trtp_long;
endmodule

// ----- hdl/spdt_checker.sv -----
// Port-level checks of the SPD timing converter and their binding.
module spdt_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_last,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input spdt_pkg::result_type   rsp_data
);
   import spdt_pkg::*;

   logic [2:0] pending_ff, pending_in;
   logic       set_in_fire;
   logic       set_out_fire;

   assign set_in_fire  = req_valid & req_ready & req_last;
   assign set_out_fire = rsp_valid & rsp_ready;

   // Track sets accepted but not yet answered
   always_comb begin
      pending_in = pending_ff + {2'd0, set_in_fire} - {2'd0, set_out_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 3'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("response changed while stalled");

   // No response without an open set
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 3'd0))
      else $error("response without a pending set");

   // Ready only while the queue has room
   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (pending_ff <= 3'd3))
      else $error("request ready with queue and back end full");

   // Nothing leaves right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");
endmodule

bind dram_timing_from_spd spdt_checker u_spdt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_last  (req_bus.last),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_data  ({rsp_bus.cl_code, rsp_bus.trp_code, rsp_bus.trcd_code, rsp_bus.tras_code,
                rsp_bus.trfc_code, rsp_bus.trrd_code, rsp_bus.twr_code, rsp_bus.twtr_code,
                rsp_bus.trtp_long})
);
